### rtl/core/lcfs_pkg.sv
// ----------------------------------------------------------------------------
// LED chain frame serializer package
// Shared constants, codes and beat types for the frame serializer.
// ----------------------------------------------------------------------------
package lcfs_pkg;

	// Frame layout: bar bytes, then red, green and blue
	localparam int BAR_LEDS      = 6;
	localparam int RGB_BYTES     = 3;
	localparam int FRAME_LEN     = BAR_LEDS + RGB_BYTES;
	localparam int FRAME_BITS    = FRAME_LEN * 8;
	localparam int BIT_POS_W     = $clog2(FRAME_BITS);
	localparam int COUNT_W       = 4;
	localparam int MASK_W        = 3;

	// Register widths
	localparam int BAR_REG_W     = 48;
	localparam int BAR_REG_BYTES = BAR_REG_W / 8;
	localparam int RGB_REG_W     = 24;
	localparam int UNIT_W        = 8;
	localparam int GAP_W         = 16;
	localparam int CFG_DATA_W    = 48;
	localparam int CFG_INDEX_W   = 3;

	// Register reset values
	localparam logic [BAR_REG_W-1:0] BAR_LEVELS_RST = 48'hFFA0_A030_3030;
	localparam logic [RGB_REG_W-1:0] RGB_LEVELS_RST = 24'h45_4050;
	localparam logic [UNIT_W-1:0]    UNIT_TICKS_RST = 8'd1;
	localparam logic [UNIT_W-1:0]    ONE_HIGH_RST   = 8'd7;
	localparam logic [UNIT_W-1:0]    ZERO_HIGH_RST  = 8'd2;
	localparam logic [UNIT_W-1:0]    BIT_UNITS_RST  = 8'd8;
	localparam logic [GAP_W-1:0]     GAP_UNITS_RST  = 16'd1000;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BAR_LEVELS = 3'd0,
		REG_RGB_LEVELS = 3'd1,
		REG_UNIT_TICKS = 3'd2,
		REG_ONE_HIGH   = 3'd3,
		REG_ZERO_HIGH  = 3'd4,
		REG_BIT_UNITS  = 3'd5,
		REG_GAP_UNITS  = 3'd6
	} cfg_reg_t;

	// Command codes
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_BAR   = 2'd1,
		MODE_COLOR = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// Serializer phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	// Input beat
	typedef struct packed {
		logic [1:0]         mode;
		logic [COUNT_W-1:0] bar_count;
		logic [MASK_W-1:0]  color_mask;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} out_item_t;

	// Control from the sequencer to the byte chain
	typedef struct packed {
		logic rotate;
		logic load_bar;
		logic load_rgb;
		logic load_clr;
	} chain_ctrl_t;

endpackage

### rtl/core/lcfs_cell.sv
// ----------------------------------------------------------------------------
// LED chain frame serializer byte cell
// Holds one frame byte; loads a new byte or shifts one bit toward its
// neighbor, taking the MSB of the next cell into its LSB.
// ----------------------------------------------------------------------------
module lcfs_cell
	import lcfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       load,
	input  logic [7:0] load_data,
	input  logic       shift_in,
	output logic       msb,
	output logic       msb_next
);

	logic [7:0] byte_q;
	logic [7:0] byte_d;

	// Select load, shift or hold
	always_comb begin
		if (load) begin
			byte_d = load_data;
		end else if (shift) begin
			byte_d = {byte_q[6:0], shift_in};
		end else begin
			byte_d = byte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else begin
			byte_q <= byte_d;
		end
	end

	assign msb      = byte_q[7];
	assign msb_next = byte_d[7];

endmodule

### rtl/core/lcfs_chain.sv
// ----------------------------------------------------------------------------
// LED chain frame serializer byte chain
// Ring of byte cells holding the frame. One rotate moves the whole frame one
// bit toward cell zero, so cell zero's MSB is always the bit on the wire and
// a full frame of rotates restores the original bytes.
// ----------------------------------------------------------------------------
module lcfs_chain
	import lcfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  chain_ctrl_t          ctrl,
	input  logic [BAR_REG_W-1:0] bar_levels,
	input  logic [RGB_REG_W-1:0] rgb_levels,
	input  logic [COUNT_W-1:0]   bar_count,
	input  logic [MASK_W-1:0]    color_mask,
	output logic                 head_next
);

	logic [FRAME_LEN-1:0] msb;
	logic [FRAME_LEN-1:0] msb_next;
	logic [COUNT_W-1:0]   lit_count;

	// Saturate the lit bar count
	assign lit_count = (bar_count > COUNT_W'(BAR_LEDS)) ? COUNT_W'(BAR_LEDS) : bar_count;

	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
		logic       ld;
		logic [7:0] ld_data;

		if (i < BAR_LEDS) begin : g_bar
			logic [7:0] lvl;
			if (i < BAR_REG_BYTES) begin : g_reg
				assign lvl = bar_levels[8*i +: 8];
			end else begin : g_none
				assign lvl = '0;
			end
			assign ld      = ctrl.load_bar | ctrl.load_clr;
			assign ld_data = (ctrl.load_bar && (COUNT_W'(i) < lit_count)) ? lvl : '0;
		end else begin : g_rgb
			assign ld      = ctrl.load_rgb | ctrl.load_clr;
			assign ld_data = (ctrl.load_rgb && color_mask[i-BAR_LEDS]) ?
				rgb_levels[8*(i-BAR_LEDS) +: 8] : '0;
		end

		lcfs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ctrl.rotate),
			.load      (ld),
			.load_data (ld_data),
			.shift_in  (msb[(i+1) % FRAME_LEN]),
			.msb       (msb[i]),
			.msb_next  (msb_next[i])
		);
	end

	assign head_next = msb_next[0];

endmodule

### rtl/core/led_chain_frame_serializer_top.sv
// ----------------------------------------------------------------------------
// LED chain frame serializer top level
// A result beat is registered into the output register, or into the skid while
// an output beat is held. Throughput: one beat per cycle unless the skid is full;
// a two-entry buffer (register plus skid) keeps input ready while one result waits.
// Reset: idle, frame bytes zero, counters zero, registers at their defaults.
// Frame: 72 bits through a 9-cell rotating byte chain, one bit per bit period.
// ----------------------------------------------------------------------------
module led_chain_frame_serializer_top
	import lcfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data
);

	// Configuration registers
	logic [BAR_REG_W-1:0] bar_levels_q;
	logic [RGB_REG_W-1:0] rgb_levels_q;
	logic [UNIT_W-1:0]    unit_ticks_q;
	logic [UNIT_W-1:0]    one_high_q;
	logic [UNIT_W-1:0]    zero_high_q;
	logic [UNIT_W-1:0]    bit_units_q;
	logic [GAP_W-1:0]     gap_units_q;

	// Sequencer state
	phase_t               phase_q, phase_d;
	logic [BIT_POS_W-1:0] bit_pos_q, bit_pos_d;
	logic [UNIT_W-1:0]    unit_cnt_q, unit_cnt_d;
	logic [UNIT_W-1:0]    tick_cnt_q, tick_cnt_d;
	logic [GAP_W-1:0]     gap_cnt_q, gap_cnt_d;

	// Output buffer
	out_item_t out_q, skid_q, res;
	logic      out_valid_q, skid_valid_q;

	logic        in_accept, is_cmd, start, reject, tick;
	logic        tick_roll, unit_roll, last_bit, gap_end;
	logic        head_next;
	logic [7:0]  high_units;
	chain_ctrl_t ctrl;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_levels_q <= BAR_LEVELS_RST;
			rgb_levels_q <= RGB_LEVELS_RST;
			unit_ticks_q <= UNIT_TICKS_RST;
			one_high_q   <= ONE_HIGH_RST;
			zero_high_q  <= ZERO_HIGH_RST;
			bit_units_q  <= BIT_UNITS_RST;
			gap_units_q  <= GAP_UNITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAR_LEVELS: bar_levels_q <= cfg_data[BAR_REG_W-1:0];
				REG_RGB_LEVELS: rgb_levels_q <= cfg_data[RGB_REG_W-1:0];
				REG_UNIT_TICKS: unit_ticks_q <= cfg_data[UNIT_W-1:0];
				REG_ONE_HIGH:   one_high_q   <= cfg_data[UNIT_W-1:0];
				REG_ZERO_HIGH:  zero_high_q  <= cfg_data[UNIT_W-1:0];
				REG_BIT_UNITS:  bit_units_q  <= cfg_data[UNIT_W-1:0];
				REG_GAP_UNITS:  gap_units_q  <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode the input beat
	assign in_ready  = !skid_valid_q;
	assign in_accept = in_valid && in_ready;
	assign is_cmd    = in_data.mode != MODE_TICK;
	assign start     = in_accept && is_cmd && (phase_q == PH_IDLE);
	assign reject    = in_accept && is_cmd && (phase_q != PH_IDLE);
	assign tick      = in_accept && !is_cmd && (phase_q != PH_IDLE);

	// Counter wrap conditions
	assign tick_roll = !(({1'b0, tick_cnt_q} + 9'd1) < {1'b0, unit_ticks_q});
	assign unit_roll = !(({1'b0, unit_cnt_q} + 9'd1) < {1'b0, bit_units_q});
	assign last_bit  = bit_pos_q == BIT_POS_W'(FRAME_BITS - 1);
	assign gap_end   = ({1'b0, gap_cnt_q} + 17'd1) >= {1'b0, gap_units_q};

	// Next state and counters
	always_comb begin
		phase_d    = phase_q;
		bit_pos_d  = bit_pos_q;
		unit_cnt_d = unit_cnt_q;
		tick_cnt_d = tick_cnt_q;
		gap_cnt_d  = gap_cnt_q;
		if (start) begin
			phase_d    = PH_SEND;
			bit_pos_d  = '0;
			unit_cnt_d = '0;
			tick_cnt_d = '0;
			gap_cnt_d  = '0;
		end else if (tick) begin
			if (!tick_roll) begin
				tick_cnt_d = tick_cnt_q + 8'd1;
			end else begin
				tick_cnt_d = '0;
				unique case (phase_q)
					PH_SEND: begin
						if (!unit_roll) begin
							unit_cnt_d = unit_cnt_q + 8'd1;
						end else begin
							unit_cnt_d = '0;
							if (!last_bit) begin
								bit_pos_d = bit_pos_q + BIT_POS_W'(1);
							end else begin
								bit_pos_d = '0;
								gap_cnt_d = '0;
								phase_d   = (gap_units_q == '0) ? PH_IDLE : PH_GAP;
							end
						end
					end
					PH_GAP: begin
						if (gap_end) begin
							phase_d   = PH_IDLE;
							gap_cnt_d = '0;
						end else begin
							gap_cnt_d = gap_cnt_q + 16'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_pos_q  <= '0;
			unit_cnt_q <= '0;
			tick_cnt_q <= '0;
			gap_cnt_q  <= '0;
		end else begin
			phase_q    <= phase_d;
			bit_pos_q  <= bit_pos_d;
			unit_cnt_q <= unit_cnt_d;
			tick_cnt_q <= tick_cnt_d;
			gap_cnt_q  <= gap_cnt_d;
		end
	end

	// Drive chain control and build the result
	always_comb begin
		ctrl.rotate   = tick && tick_roll && unit_roll && (phase_q == PH_SEND);
		ctrl.load_bar = start && (in_data.mode == MODE_BAR);
		ctrl.load_rgb = start && (in_data.mode == MODE_COLOR);
		ctrl.load_clr = start && (in_data.mode == MODE_CLEAR);
		high_units    = head_next ? one_high_q : zero_high_q;
		res.line_level = (phase_d == PH_SEND) && (unit_cnt_d < high_units);
		res.busy_res   = phase_d != PH_IDLE;
		res.frame_done = tick && tick_roll &&
			(((phase_q == PH_SEND) && unit_roll && last_bit && (gap_units_q == '0)) ||
			((phase_q == PH_GAP) && gap_end));
		res.rejected   = reject;
	end

	lcfs_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.bar_levels (bar_levels_q),
		.rgb_levels (rgb_levels_q),
		.bar_count  (in_data.bar_count),
		.color_mask (in_data.color_mask),
		.head_next  (head_next)
	);

	// Track output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (in_accept) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q  <= skid_valid_q | in_accept;
			skid_valid_q <= 1'b0;
		end
	end

	// Hold or advance the result payload
	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (in_accept) begin
				skid_q <= res;
			end
		end else begin
			out_q <= skid_valid_q ? skid_q : res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Skid entry only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat held without an output beat");

	// Idle sequencer keeps its bit-level counters cleared
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> ((tick_cnt_q == '0) && (unit_cnt_q == '0) &&
		(bit_pos_q == '0) && (gap_cnt_q == '0)))
		else $error("counters not cleared while idle");

	// Chain rotates only while sending
	a_rotate_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rotate |-> ((phase_q == PH_SEND) && !start))
		else $error("chain rotated outside of a frame");

	// An accepted command enters the send phase next cycle
	a_start_sends: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (phase_q == PH_SEND))
		else $error("accepted command did not start a frame");

endmodule

### tb/lcfs_line_monitor.sv
// ----------------------------------------------------------------------------
// LED chain frame serializer line monitor
// Watches the register port and both beat channels of the serializer. A
// private model of the frame buffer, bit timing and latch gap works out each
// result beat as its command or tick beat is accepted. Result beats are then
// compared field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lcfs_line_monitor
	import lcfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  in_item_t               in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  out_item_t              out_data,
	output int                     mismatches,
	output int                     pending,
	output logic                   line_busy
);

	// Keep the log readable when the design is badly off
	localparam int MAX_REPORTS = 100;

	// Register copies
	logic [BAR_REG_W-1:0] bar_reg;
	logic [RGB_REG_W-1:0] rgb_reg;
	logic [UNIT_W-1:0]    ticks_per_unit;
	logic [UNIT_W-1:0]    one_high;
	logic [UNIT_W-1:0]    zero_high;
	logic [UNIT_W-1:0]    units_per_bit;
	logic [GAP_W-1:0]     gap_len;

	// Serializer state
	logic [7:0]           frame_q [FRAME_LEN];
	logic [BIT_POS_W-1:0] bit_idx;
	logic [UNIT_W-1:0]    unit_cnt;
	logic [UNIT_W-1:0]    tick_cnt;
	logic [GAP_W-1:0]     gap_cnt;
	phase_t               ph;

	out_item_t            wire_results_q [$];
	out_item_t            awaited;
	int                   result_no;

	function automatic void reset_serializer();
		bar_reg        = BAR_LEVELS_RST;
		rgb_reg        = RGB_LEVELS_RST;
		ticks_per_unit = UNIT_TICKS_RST;
		one_high       = ONE_HIGH_RST;
		zero_high      = ZERO_HIGH_RST;
		units_per_bit  = BIT_UNITS_RST;
		gap_len        = GAP_UNITS_RST;
		foreach (frame_q[i])
			frame_q[i] = 8'h00;
		bit_idx  = '0;
		unit_cnt = '0;
		tick_cnt = '0;
		gap_cnt  = '0;
		ph       = PH_IDLE;
	endfunction

	function automatic void write_copy(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (cfg_reg_t'(idx))
			REG_BAR_LEVELS: bar_reg        = val[BAR_REG_W-1:0];
			REG_RGB_LEVELS: rgb_reg        = val[RGB_REG_W-1:0];
			REG_UNIT_TICKS: ticks_per_unit = val[UNIT_W-1:0];
			REG_ONE_HIGH:   one_high       = val[UNIT_W-1:0];
			REG_ZERO_HIGH:  zero_high      = val[UNIT_W-1:0];
			REG_BIT_UNITS:  units_per_bit  = val[UNIT_W-1:0];
			REG_GAP_UNITS:  gap_len        = val[GAP_W-1:0];
			default: ;
		endcase
	endfunction

	// Wire is high while the unit count of the current bit is under its high time
	function automatic logic line_high();
		logic             bitv;
		logic [UNIT_W-1:0] high;
		if (ph != PH_SEND || bit_idx >= FRAME_BITS)
			return 1'b0;
		bitv = frame_q[bit_idx >> 3][3'd7 - bit_idx[2:0]];
		high = bitv ? one_high : zero_high;
		return unit_cnt < high;
	endfunction

	// Advance one tick; return high when the frame ends, with its latch gap if any
	function automatic logic advance_tick();
		if (ph == PH_IDLE)
			return 1'b0;
		if (tick_cnt + 1 < ticks_per_unit) begin
			tick_cnt++;
			return 1'b0;
		end
		tick_cnt = '0;
		if (ph == PH_SEND) begin
			if (unit_cnt + 1 < units_per_bit) begin
				unit_cnt++;
				return 1'b0;
			end
			unit_cnt = '0;
			bit_idx++;
			if (bit_idx < FRAME_BITS)
				return 1'b0;
			ph      = PH_GAP;
			gap_cnt = '0;
			// no gap: the frame ends with its last bit
			if (gap_len == 0) begin
				ph      = PH_IDLE;
				bit_idx = '0;
				return 1'b1;
			end
			return 1'b0;
		end
		if (gap_cnt + 1 >= gap_len) begin
			ph      = PH_IDLE;
			gap_cnt = '0;
			bit_idx = '0;
			return 1'b1;
		end
		gap_cnt++;
		return 1'b0;
	endfunction

	// Apply one beat and return the result beat it causes
	function automatic out_item_t serialize_step(in_item_t beat);
		out_item_t res;
		int        lit;
		res = '0;
		if (mode_t'(beat.mode) == MODE_TICK) begin
			res.frame_done = advance_tick();
		end else if (ph != PH_IDLE) begin
			res.rejected = 1'b1;
		end else begin
			case (mode_t'(beat.mode))
				MODE_BAR: begin
					lit = (beat.bar_count > BAR_LEDS) ? BAR_LEDS : int'(beat.bar_count);
					for (int i = 0; i < BAR_LEDS; i++)
						frame_q[i] = (i < lit && i < BAR_REG_BYTES) ? bar_reg[8*i +: 8] : 8'h00;
				end
				MODE_COLOR: begin
					for (int i = 0; i < RGB_BYTES; i++)
						frame_q[BAR_LEDS+i] = beat.color_mask[i] ? rgb_reg[8*i +: 8] : 8'h00;
				end
				default: begin
					foreach (frame_q[i])
						frame_q[i] = 8'h00;
				end
			endcase
			// start the frame without advancing time
			ph       = PH_SEND;
			bit_idx  = '0;
			unit_cnt = '0;
			tick_cnt = '0;
			gap_cnt  = '0;
		end
		res.line_level = line_high();
		res.busy_res   = (ph != PH_IDLE);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_REPORTS)
			$display("%0t: result %0d: %s", $time, result_no, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic got, logic want);
		if (got !== want)
			report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
	endtask

	// Retire results, then predict the beat accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_serializer();
			wire_results_q.delete();
			mismatches = 0;
			result_no  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (wire_results_q.size() == 0) begin
					report_mismatch("result beat with nothing awaited");
				end else begin
					awaited = wire_results_q.pop_front();
					check_field("line_level", out_data.line_level, awaited.line_level);
					check_field("busy_res", out_data.busy_res, awaited.busy_res);
					check_field("frame_done", out_data.frame_done, awaited.frame_done);
					check_field("rejected", out_data.rejected, awaited.rejected);
				end
				result_no++;
			end
			if (in_valid && in_ready)
				wire_results_q.push_back(serialize_step(in_data));
			if (cfg_we)
				write_copy(cfg_index, cfg_data);
		end
		pending   = wire_results_q.size();
		line_busy = (ph != PH_IDLE);
	end

endmodule

### tb/led_chain_frame_serializer_top_tb.sv
// ----------------------------------------------------------------------------
// LED chain frame serializer testbench
// Drives command and tick beats into the serializer under several register
// settings: a directed run over saturation, masks, rejection and timing corner
// cases, then random traffic with sender and receiver stalls. The line
// monitor predicts and checks every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_chain_frame_serializer_top_tb;
	import lcfs_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_BEATS  = 180;
	localparam int RESET_TICKS  = 40;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;

	int                     mismatches;
	int                     pending;
	logic                   line_busy;

	int                     send_idle_pct = 31;
	int                     recv_idle_pct = 58;
	logic                   hold_req      = 1'b0;
	int                     hold_left     = 0;
	int                     cycles        = 0;

	led_chain_frame_serializer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	lcfs_line_monitor line_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.pending    (pending),
		.line_busy  (line_busy)
	);

	always #5 clk = ~clk;

	// Drop ready at random, or for a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("led_chain_frame_serializer_top: mismatch");
			$finish;
		end
	end

	function automatic in_item_t tick_beat();
		in_item_t b;
		b.mode       = MODE_TICK;
		b.bar_count  = COUNT_W'($urandom_range(0, 15));
		b.color_mask = MASK_W'($urandom_range(0, 7));
		return b;
	endfunction

	// Mostly commands on an idle line, mostly ticks on a busy one
	function automatic in_item_t pick_beat(logic busy);
		in_item_t b;
		int       roll;
		b    = tick_beat();
		roll = $urandom_range(0, 99);
		if (busy ? (roll < 6) : (roll >= 8))
			b.mode = mode_t'($urandom_range(MODE_BAR, MODE_CLEAR));
		return b;
	endfunction

	// Idle the sender at random; end on a falling edge
	task automatic sender_gap();
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
	endtask

	// Offer one beat and hold it until accepted
	task automatic present(in_item_t beat);
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic issue(mode_t m, int count, int mask);
		in_item_t b;
		b.mode       = m;
		b.bar_count  = COUNT_W'(count);
		b.color_mask = MASK_W'(mask);
		sender_gap();
		present(b);
	endtask

	// Offer a run of tick beats
	task automatic tick_run(int n);
		for (int i = 0; i < n; i++) begin
			sender_gap();
			present(tick_beat());
		end
	endtask

	// Tick until the frame and its gap are over
	task automatic run_out_frame();
		sender_gap();
		while (line_busy) begin
			present(tick_beat());
			sender_gap();
		end
		in_valid <= 1'b0;
	endtask

	task automatic frame_cmd(mode_t m, int count, int mask);
		issue(m, count, mask);
		run_out_frame();
	endtask

	// Hold the sender until every result beat is in
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic write_all(logic [BAR_REG_W-1:0] bars, logic [RGB_REG_W-1:0] rgb,
			logic [UNIT_W-1:0] ticks, logic [UNIT_W-1:0] one_hi,
			logic [UNIT_W-1:0] zero_hi, logic [UNIT_W-1:0] bits, logic [GAP_W-1:0] gap);
		write_reg(REG_BAR_LEVELS, CFG_DATA_W'(bars));
		write_reg(REG_RGB_LEVELS, CFG_DATA_W'(rgb));
		write_reg(REG_UNIT_TICKS, CFG_DATA_W'(ticks));
		write_reg(REG_ONE_HIGH, CFG_DATA_W'(one_hi));
		write_reg(REG_ZERO_HIGH, CFG_DATA_W'(zero_hi));
		write_reg(REG_BIT_UNITS, CFG_DATA_W'(bits));
		write_reg(REG_GAP_UNITS, CFG_DATA_W'(gap));
	endtask

	// Random traffic, with an optional receiver hold-off and sender pause
	task automatic run_phase(int beats, int send_pct, int recv_pct, int hold_at, int pause_at);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < beats; i++) begin
			sender_gap();
			present(pick_beat(line_busy));
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == pause_at)
				settle();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset registers: idle tick, saturating bar count, commands while sending,
		// then the first bits at default timing
		issue(MODE_TICK, 9, 5);
		issue(MODE_BAR, 15, 0);
		issue(MODE_COLOR, 0, 7);
		issue(MODE_CLEAR, 0, 0);
		issue(MODE_BAR, 2, 3);
		tick_run(RESET_TICKS);

		// Full levels; zero tick count, zero bit length, zero high time, no gap;
		// finish the running frame at the new timing first
		settle();
		write_all('1, '1, 8'd0, 8'd1, 8'd0, 8'd0, 16'd0);
		run_out_frame();
		frame_cmd(MODE_BAR, 6, 0);
		frame_cmd(MODE_COLOR, 0, 5);
		frame_cmd(MODE_BAR, 7, 0);
		frame_cmd(MODE_CLEAR, 15, 7);

		// Empty levels; one-unit bits, high time past the bit period
		settle();
		write_all('0, '0, 8'd1, 8'd200, 8'd1, 8'd1, 16'd2);
		frame_cmd(MODE_BAR, 0, 7);
		frame_cmd(MODE_COLOR, 6, 0);

		// Mixed levels, longer bits
		settle();
		write_all(48'({$urandom(), $urandom()}), 24'($urandom()), 8'd1, 8'd3, 8'd1,
			8'd2, 16'd1);
		frame_cmd(MODE_BAR, 3, 2);
		frame_cmd(MODE_COLOR, 1, 6);

		// Random traffic: sender light, receiver heavy idling; long hold-off
		settle();
		write_all(48'({$urandom(), $urandom()}), 24'($urandom()), 8'd1,
			8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
			8'($urandom_range(0, 2)), 16'($urandom_range(0, 8)));
		run_phase(PHASE_BEATS, 31, 58, 90, -1);
		run_out_frame();

		// Swapped idling; one hold-off and one full pause
		settle();
		write_all(48'({$urandom(), $urandom()}), 24'($urandom()),
			8'($urandom_range(0, 2)), 8'($urandom_range(0, 3)),
			8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)),
			16'($urandom_range(0, 8)));
		run_phase(PHASE_BEATS, 58, 31, 130, 60);
		run_out_frame();

		// Largest timing, no idling
		settle();
		write_all(48'({$urandom(), $urandom()}), 24'($urandom()), 8'd255, 8'd255, 8'd1,
			8'd255, 16'd65535);
		run_phase(PHASE_BEATS, 0, 0, -1, -1);

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("led_chain_frame_serializer_top: match");
		else
			$display("led_chain_frame_serializer_top: mismatch");
		$finish;
	end

endmodule
